### hw/rtl/grp_pkg.sv
// shared types and constants of the guillotine rectangle packer
package grp_pkg;

  localparam int unsigned CoordW  = 13;  // x, y and input dimensions
  localparam int unsigned ExtentW = 14;  // stored free-rectangle width and height
  localparam int unsigned CanvasW = 14;  // canvas size on the result ports

  // one free-list entry
  typedef struct packed {
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [ExtentW-1:0] w;
    logic [ExtentW-1:0] h;
    logic               taken;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic load;    // capture an input transfer
    logic first;   // first rectangle of a set
    logic scan;    // first-fit search over the free list
    logic grow;    // one canvas doubling
    logic mark;    // mark the chosen entry taken
    logic rem_r;   // append right remainder
    logic rem_b;   // append bottom remainder
    logic finish;  // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;      // item opens a new set
    logic hit;        // search found an entry
    logic miss;       // search exhausted the list
    logic grow_fail;  // doubling would pass the canvas limit
    logic grow_fit;   // new strip takes the rectangle
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

### hw/rtl/guillotine_rect_packer_core.sv
// top level of the guillotine first-fit rectangle packer
// sequence: the first rectangle of a set goes from decide straight to hand-over; a later one is
//   searched, grown, marked and split into remainders before hand-over, held while a result waits
// throughput: one item at a time, next transfer in the cycle after the result register loads
// reset: canvas, fill count and control cleared at once; free-list ram is not cleared,
//   since only entries below the fill count are ever read
module guillotine_rect_packer_core #(
  parameter int unsigned MAX_FREE_RECTS = 256,
  parameter int unsigned MAX_CANVAS     = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         new_set_i,
  input  logic [grp_pkg::CoordW-1:0]   rect_width_i,
  input  logic [grp_pkg::CoordW-1:0]   rect_height_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [grp_pkg::CoordW-1:0]   place_x_o,
  output logic [grp_pkg::CoordW-1:0]   place_y_o,
  output logic [grp_pkg::CanvasW-1:0]  canvas_width_o,
  output logic [grp_pkg::CanvasW-1:0]  canvas_height_o,
  output logic                         status_o,
  output logic                         space_lost_o
);

  // controller and datapath talk only through these two structs
  grp_pkg::cmd_t    cmd;
  grp_pkg::status_t st;

  // state machine: decide, search, grow, mark, append remainders, hand over
  grp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // canvas registers, free-list ram, search pipeline and result register;
  // the result register lets a new transfer in while the last result still waits
  grp_dpath #(
    .MAX_FREE_RECTS (MAX_FREE_RECTS),
    .MAX_CANVAS     (MAX_CANVAS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .new_set_i       (new_set_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .place_x_o       (place_x_o),
    .place_y_o       (place_y_o),
    .canvas_width_o  (canvas_width_o),
    .canvas_height_o (canvas_height_o),
    .status_o        (status_o),
    .space_lost_o    (space_lost_o)
  );

  // a refused rectangle always reports the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (place_x_o == '0 && place_y_o == '0))
    else $error("refused rectangle with non-zero placement");

  // a placed rectangle always sits on a non-empty canvas
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (canvas_width_o != '0 && canvas_height_o != '0))
    else $error("placement reported on an empty canvas");

  // after an input transfer the block is busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transfer taken while an item is in work");

  // no two of search, grow, mark and the two remainder appends are commanded together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.scan, cmd.grow, cmd.mark, cmd.rem_r, cmd.rem_b}) <= 1)
    else $error("more than one free-list operation commanded");

endmodule

### hw/rtl/grp_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module grp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/grp_ctrl.sv
// sequencing state machine of the rectangle packer
module grp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  grp_pkg::status_t st_i,
  output grp_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StScan,
    StGrow,
    StMark,
    StRemR,
    StRemB,
    StFin
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = StDecide;
      end
      StDecide: begin
        if (st_i.start) begin
          cmd_o.first = 1'b1;
          state_d     = StFin;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (st_i.hit) state_d = StMark;
        else if (st_i.miss) state_d = StGrow;
      end
      StGrow: begin
        cmd_o.grow = 1'b1;
        if (st_i.grow_fail) state_d = StFin;
        else if (st_i.grow_fit) state_d = StRemR;
      end
      StMark: begin
        cmd_o.mark = 1'b1;
        state_d    = StRemR;
      end
      StRemR: begin
        cmd_o.rem_r = 1'b1;
        state_d     = StRemB;
      end
      StRemB: begin
        cmd_o.rem_b = 1'b1;
        state_d     = StFin;
      end
      StFin: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

### hw/rtl/grp_dpath.sv
// datapath of the rectangle packer: canvas, free list, search and result register
module grp_dpath #(
  parameter int unsigned MAX_FREE_RECTS = 256,
  parameter int unsigned MAX_CANVAS     = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grp_pkg::cmd_t                       cmd_i,
  output grp_pkg::status_t                    st_o,
  input  logic                                new_set_i,
  input  logic [grp_pkg::CoordW-1:0]          rect_width_i,
  input  logic [grp_pkg::CoordW-1:0]          rect_height_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [grp_pkg::CoordW-1:0]          place_x_o,
  output logic [grp_pkg::CoordW-1:0]          place_y_o,
  output logic [grp_pkg::CanvasW-1:0]         canvas_width_o,
  output logic [grp_pkg::CanvasW-1:0]         canvas_height_o,
  output logic                                status_o,
  output logic                                space_lost_o
);

  localparam int unsigned IdxW = $clog2(MAX_FREE_RECTS);
  localparam int unsigned CntW = $clog2(MAX_FREE_RECTS + 1);
  localparam int unsigned CvW  = $clog2(MAX_CANVAS + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_FREE_RECTS);
  localparam logic [CvW:0]    LimitDb = (CvW + 1)'(MAX_CANVAS);

  // state
  logic [CvW-1:0]  canvas_w_q, canvas_h_q;
  logic [CntW-1:0] free_cnt_q;
  logic [CntW-1:0] issue_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            out_valid_q;

  // item and working registers
  logic [grp_pkg::CoordW-1:0] rw_q, rh_q;
  logic                       start_q;
  grp_pkg::entry_t            hit_q;
  logic [IdxW-1:0]            hit_idx_q;
  logic [grp_pkg::CoordW-1:0] px_q, py_q;
  logic                       fail_q, lost_q;

  // result register
  logic [grp_pkg::CoordW-1:0]  out_x_q, out_y_q;
  logic [grp_pkg::CanvasW-1:0] out_cw_q, out_ch_q;
  logic                        out_st_q, out_lost_q;

  grp_pkg::entry_t rd_entry, strip, rem_r_ent, rem_b_ent, wr_data;
  logic [grp_pkg::EntryW-1:0] rdata;
  logic [IdxW-1:0]            wr_addr;
  logic                       wr_en, append, lost_set;

  logic [grp_pkg::ExtentW-1:0] rw_ext, rh_ext;
  logic                        full, hit, miss;
  logic                        wider, grow_fail, grow_fit;
  logic [CvW-1:0]              old_dim;
  logic [CvW:0]                dbl;
  logic                        cond_r, cond_b, oversize;

  assign rw_ext   = {1'b0, rw_q};
  assign rh_ext   = {1'b0, rh_q};
  assign full     = (free_cnt_q == CntMax);
  assign rd_entry = grp_pkg::entry_t'(rdata);

  // first-fit search, one entry a cycle through the registered read
  assign hit  = pend_q && !rd_entry.taken && (rw_ext <= rd_entry.w) && (rh_ext <= rd_entry.h);
  assign miss = !pend_q && (issue_q >= free_cnt_q);

  // canvas doubling and its strip
  assign wider     = (canvas_w_q > canvas_h_q);
  assign old_dim   = wider ? canvas_h_q : canvas_w_q;
  assign dbl       = {old_dim, 1'b0};
  assign grow_fail = (dbl > LimitDb);

  always_comb begin
    strip.taken = 1'b0;
    if (wider) begin
      strip.x = '0;
      strip.y = grp_pkg::CoordW'(old_dim);
      strip.w = grp_pkg::ExtentW'(canvas_w_q);
      strip.h = grp_pkg::ExtentW'(old_dim);
    end else begin
      strip.x = grp_pkg::CoordW'(old_dim);
      strip.y = '0;
      strip.w = grp_pkg::ExtentW'(old_dim);
      strip.h = grp_pkg::ExtentW'(canvas_h_q);
    end
  end

  assign grow_fit = !grow_fail && !full && (rw_ext <= strip.w) && (rh_ext <= strip.h);

  // remainders of the chosen entry
  assign cond_r = (hit_q.w > rw_ext) && (hit_q.h != '0);
  assign cond_b = (hit_q.h > rh_ext) && (rw_q != '0);

  always_comb begin
    rem_r_ent.x     = grp_pkg::CoordW'(hit_q.x + rw_q);
    rem_r_ent.y     = hit_q.y;
    rem_r_ent.w     = hit_q.w - rw_ext;
    rem_r_ent.h     = hit_q.h;
    rem_r_ent.taken = 1'b0;
    rem_b_ent.x     = hit_q.x;
    rem_b_ent.y     = grp_pkg::CoordW'(hit_q.y + rh_q);
    rem_b_ent.w     = rw_ext;
    rem_b_ent.h     = hit_q.h - rh_ext;
    rem_b_ent.taken = 1'b0;
  end

  // free-list write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_cnt_q[IdxW-1:0];
    wr_data = strip;
    if (cmd_i.grow && !grow_fail && !full) begin
      wr_en         = 1'b1;
      wr_data.taken = grow_fit;
    end else if (cmd_i.mark) begin
      wr_en         = 1'b1;
      wr_addr       = hit_idx_q;
      wr_data       = hit_q;
      wr_data.taken = 1'b1;
    end else if (cmd_i.rem_r && cond_r && !full) begin
      wr_en   = 1'b1;
      wr_data = rem_r_ent;
    end else if (cmd_i.rem_b && cond_b && !full) begin
      wr_en   = 1'b1;
      wr_data = rem_b_ent;
    end
  end

  assign append   = wr_en && !cmd_i.mark;
  assign lost_set = full && ((cmd_i.grow && !grow_fail) || (cmd_i.rem_r && cond_r) ||
                             (cmd_i.rem_b && cond_b));

  assign oversize = ({19'd0, rw_q} > 32'(MAX_CANVAS)) || ({19'd0, rh_q} > 32'(MAX_CANVAS));

  grp_ram #(
    .WIDTH (grp_pkg::EntryW),
    .DEPTH (MAX_FREE_RECTS)
  ) u_free_list (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q  <= '0;
      canvas_h_q  <= '0;
      free_cnt_q  <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        issue_q <= '0;
        pend_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= (issue_q < free_cnt_q);
        if (issue_q < free_cnt_q) issue_q <= issue_q + CntW'(1);
      end
      if (cmd_i.first) begin
        free_cnt_q <= '0;
        if (oversize) begin
          canvas_w_q <= '0;
          canvas_h_q <= '0;
        end else begin
          canvas_w_q <= (rw_q == '0) ? CvW'(1) : CvW'(rw_q);
          canvas_h_q <= (rh_q == '0) ? CvW'(1) : CvW'(rh_q);
        end
      end else begin
        if (append) free_cnt_q <= free_cnt_q + CntW'(1);
        if (cmd_i.grow && !grow_fail) begin
          if (wider) canvas_h_q <= dbl[CvW-1:0];
          else canvas_w_q <= dbl[CvW-1:0];
        end
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= issue_q[IdxW-1:0];
    if (cmd_i.load) begin
      rw_q    <= rect_width_i;
      rh_q    <= rect_height_i;
      start_q <= new_set_i || (canvas_w_q == '0) || (canvas_h_q == '0);
      px_q    <= '0;
      py_q    <= '0;
      fail_q  <= 1'b0;
      lost_q  <= 1'b0;
    end else begin
      if (cmd_i.first && oversize) fail_q <= 1'b1;
      if (cmd_i.grow && grow_fail) fail_q <= 1'b1;
      if (lost_set) lost_q <= 1'b1;
      if (cmd_i.scan && hit) begin
        hit_q     <= rd_entry;
        hit_idx_q <= pend_idx_q;
        px_q      <= rd_entry.x;
        py_q      <= rd_entry.y;
      end else if (cmd_i.grow && grow_fit) begin
        hit_q     <= strip;
        hit_idx_q <= free_cnt_q[IdxW-1:0];
        px_q      <= strip.x;
        py_q      <= strip.y;
      end
    end
    if (cmd_i.finish) begin
      out_x_q    <= px_q;
      out_y_q    <= py_q;
      out_cw_q   <= grp_pkg::CanvasW'(canvas_w_q);
      out_ch_q   <= grp_pkg::CanvasW'(canvas_h_q);
      out_st_q   <= fail_q;
      out_lost_q <= lost_q;
    end
  end

  assign st_o.start     = start_q;
  assign st_o.hit       = hit;
  assign st_o.miss      = miss;
  assign st_o.grow_fail = grow_fail;
  assign st_o.grow_fit  = grow_fit;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign place_x_o       = out_x_q;
  assign place_y_o       = out_y_q;
  assign canvas_width_o  = out_cw_q;
  assign canvas_height_o = out_ch_q;
  assign status_o        = out_st_q;
  assign space_lost_o    = out_lost_q;

endmodule
